/* hw/rtl/trat_pkg.sv */
// Shared widths, constants, register indexes and result types for the tick rate throttle.
package trat_pkg;

    localparam int TICK_W      = 16;
    localparam int NOM_W       = 10;
    localparam int TARGET_W    = 16;
    localparam int SLEEP_W     = 11;
    localparam int SLEEP_OUT_W = 10;
    localparam int MEM_W       = 40;
    localparam int MIB_W       = 20;
    localparam int MIB_SHIFT   = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 40;
    localparam int PROBE_CNT   = 3;
    localparam int PROBE_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASELINE = 2'd2;

    localparam logic [NOM_W-1:0]    NOMINAL_RESET = 10'd50;
    localparam logic [TARGET_W-1:0] TARGET_RESET  = 16'd0;

    localparam logic [TICK_W-1:0] TICK_SAT    = 16'hFFFF;
    localparam logic [TICK_W-1:0] TICK_RESET  = 16'd1000;
    localparam logic [TICK_W-1:0] WANT_MARGIN = 16'd20;

    localparam logic signed [SLEEP_W-1:0] SLEEP_MAX  = 11'sh3FF;
    localparam logic signed [SLEEP_W-1:0] SLEEP_MIN  = 11'sh400;
    localparam logic signed [SLEEP_W-1:0] SLEEP_ZERO = 11'sh000;
    localparam logic [SLEEP_OUT_W-1:0]    SLEEP_OUT_MAX = 10'd1000;

    localparam logic [MEM_W-1:0] RAM_STEP_BYTES = 40'd52428800;

    // Probe slot code meaning that no probe is running.
    localparam logic [PROBE_IDX_W-1:0] PROBE_NONE = 2'd3;
    localparam logic [PROBE_IDX_W-1:0] PROBE_CUR  = 2'd0;
    localparam logic [PROBE_IDX_W-1:0] PROBE_UP   = 2'd1;
    localparam logic [PROBE_IDX_W-1:0] PROBE_DOWN = 2'd2;

    typedef struct packed {
        logic [SLEEP_OUT_W-1:0] sleep_ms;
        logic                   cpu_warning_valid;
        logic [TICK_W-1:0]      cpu_warning_ticks;
        logic [TICK_W-1:0]      ticks_last_second;
    } rate_res_t;

    typedef struct packed {
        logic             ram_warning_valid;
        logic [MIB_W-1:0] ram_warning_mib;
    } ram_res_t;

    // Step the sleep amount by one in either direction, saturating at the range ends.
    function automatic logic signed [SLEEP_W-1:0] sleep_adjust(
        input logic signed [SLEEP_W-1:0] s,
        input logic                      up,
        input logic                      down
    );
        logic signed [SLEEP_W-1:0] r;
        begin
            r = s;
            if (up && (s != SLEEP_MAX))
            begin
                r = s + 11'sd1;
            end
            else if (down && (s != SLEEP_MIN))
            begin
                r = s - 11'sd1;
            end
            return r;
        end
    endfunction

endpackage

/* hw/rtl/trat_rate.sv */
// Tick counting, slow-second warning and the three-probe sleep search.
module trat_rate
    import trat_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                second_elapsed,
    input  logic [NOM_W-1:0]    nominal,
    input  logic [TARGET_W-1:0] target,
    output rate_res_t           res
);

    logic [TICK_W-1:0]             tick_count_reg;
    logic [TICK_W-1:0]             tick_count_next;
    logic [TICK_W-1:0]             last_ticks_reg;
    logic [TICK_W-1:0]             last_ticks_next;
    logic signed [SLEEP_W-1:0]     sleep_reg;
    logic signed [SLEEP_W-1:0]     sleep_next;
    logic [TICK_W-1:0]             probe_reg [PROBE_CNT];
    logic [TICK_W-1:0]             probe_next [PROBE_CNT];
    logic [PROBE_IDX_W-1:0]        slot_reg;
    logic [PROBE_IDX_W-1:0]        slot_next;

    logic [TICK_W-1:0]             cur;
    logic                          throttle_on;
    logic                          do_throttle;
    logic [TICK_W-1:0]             rec [PROBE_CNT];
    logic signed [SLEEP_W-1:0]     s1;
    logic signed [SLEEP_W-1:0]     s2;
    logic signed [SLEEP_W-1:0]     s3;
    logic [PROBE_IDX_W-1:0]        pick;
    logic [TICK_W-1:0]             wanted_base;
    logic [TICK_W-1:0]             wanted;
    logic                          up3;
    logic                          down3;
    logic                          retest;
    logic signed [SLEEP_W-1:0]     sleep_eff;

    assign cur         = (tick_count_reg == TICK_SAT) ? tick_count_reg
                                                      : tick_count_reg + 16'd1;
    assign throttle_on = (target != '0);
    assign do_throttle = second_elapsed && throttle_on;
    assign wanted_base = {{(TICK_W-NOM_W){1'b0}}, nominal} + WANT_MARGIN;
    assign wanted      = (target > wanted_base) ? target : wanted_base;

    // A running probe records the rate it measured and undoes its sleep offset.
    always_comb
    begin
        for (int i = 0; i < PROBE_CNT; i++)
        begin
            rec[i] = probe_reg[i];
        end
        s1 = sleep_reg;
        if (slot_reg != PROBE_NONE)
        begin
            if (probe_reg[slot_reg] == '0)
            begin
                rec[slot_reg] = cur;
            end
            s1 = sleep_adjust(sleep_reg, slot_reg == PROBE_DOWN, slot_reg == PROBE_UP);
        end
    end

    // The first empty probe runs next, offsetting the sleep for its measurement.
    always_comb
    begin
        priority if (rec[0] == '0)
        begin
            pick = PROBE_CUR;
        end
        else if (rec[1] == '0)
        begin
            pick = PROBE_UP;
        end
        else if (rec[2] == '0)
        begin
            pick = PROBE_DOWN;
        end
        else
        begin
            pick = PROBE_NONE;
        end
    end

    assign s2 = sleep_adjust(s1, pick == PROBE_UP, pick == PROBE_DOWN);

    // With all three probes in hand, decide on a step and whether to measure again.
    always_comb
    begin
        up3    = 1'b0;
        down3  = 1'b0;
        retest = 1'b0;
        if (pick == PROBE_NONE)
        begin
            priority if ((rec[0] < rec[1]) || (rec[0] > rec[2]))
            begin
                retest = 1'b1;
            end
            else if (cur >= wanted)
            begin
                if ((cur > rec[2]) || (rec[1] > wanted))
                begin
                    up3    = 1'b1;
                    retest = 1'b1;
                end
            end
            else if (s2 > SLEEP_ZERO)
            begin
                down3  = 1'b1;
                retest = 1'b1;
            end
            else
            begin
                retest = 1'b0;
            end
        end
    end

    assign s3 = sleep_adjust(s2, up3, down3);

    always_comb
    begin
        tick_count_next = second_elapsed ? '0 : cur;
        last_ticks_next = second_elapsed ? cur : last_ticks_reg;
        sleep_next      = sleep_reg;
        slot_next       = slot_reg;
        for (int i = 0; i < PROBE_CNT; i++)
        begin
            probe_next[i] = probe_reg[i];
        end
        if (do_throttle)
        begin
            sleep_next = s3;
            slot_next  = pick;
            for (int i = 0; i < PROBE_CNT; i++)
            begin
                probe_next[i] = retest ? '0 : rec[i];
            end
        end
    end

    assign sleep_eff = do_throttle ? s3 : sleep_reg;

    always_comb
    begin
        res.sleep_ms = '0;
        if (throttle_on && (sleep_eff > SLEEP_ZERO))
        begin
            if (sleep_eff > $signed({1'b0, SLEEP_OUT_MAX}))
            begin
                res.sleep_ms = SLEEP_OUT_MAX;
            end
            else
            begin
                res.sleep_ms = sleep_eff[SLEEP_OUT_W-1:0];
            end
        end
        res.cpu_warning_valid = second_elapsed
                                && (cur < {{(TICK_W-NOM_W){1'b0}}, nominal});
        res.cpu_warning_ticks = res.cpu_warning_valid ? cur : '0;
        res.ticks_last_second = last_ticks_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= TICK_RESET;
            last_ticks_reg <= '0;
            sleep_reg      <= SLEEP_ZERO;
            slot_reg       <= PROBE_NONE;
            for (int i = 0; i < PROBE_CNT; i++)
            begin
                probe_reg[i] <= '0;
            end
        end
        else if (fire)
        begin
            tick_count_reg <= tick_count_next;
            last_ticks_reg <= last_ticks_next;
            sleep_reg      <= sleep_next;
            slot_reg       <= slot_next;
            for (int i = 0; i < PROBE_CNT; i++)
            begin
                probe_reg[i] <= probe_next[i];
            end
        end
    end

endmodule

/* hw/rtl/trat_ram.sv */
// Memory growth tracking against the highest level already reported.
module trat_ram
    import trat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [MEM_W-1:0] memory_bytes,
    input  logic             base_load,
    input  logic [MEM_W-1:0] base_value,
    output ram_res_t         res
);

    logic [MEM_W-1:0] peak_reg;
    logic [MEM_W-1:0] peak_next;
    logic [MEM_W-1:0] growth;
    logic             warn;

    assign growth = memory_bytes - peak_reg;
    assign warn   = (memory_bytes > peak_reg) && (growth > RAM_STEP_BYTES);

    assign res.ram_warning_valid = warn;
    assign res.ram_warning_mib   = warn ? memory_bytes[MIB_SHIFT +: MIB_W] : '0;

    // A baseline write restarts tracking from the new value.
    always_comb
    begin
        priority if (base_load)
        begin
            peak_next = base_value;
        end
        else if (fire && warn)
        begin
            peak_next = memory_bytes;
        end
        else
        begin
            peak_next = peak_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else
        begin
            peak_reg <= peak_next;
        end
    end

endmodule

/* hw/rtl/tick_rate_auto_throttle_core.sv */
// Top level of the tick rate throttle: request registers, configuration and result register.
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    second_elapsed, memory_bytes
//   out       output     out_valid/out_stall  sleep_ms, cpu/ram warnings, ticks_last_second
//   cfg       input      cfg_wr_en            cfg_index, cfg_data
//
// One request a cycle is sustained while the output is not stalled. A request waits in the input
// register, is evaluated against the tick, probe and peak state and lands in the result register,
// from which its result is presented to the receiver.
// After reset the block takes requests at once.
// A stalled result holds the result register; the input register still takes one request.
module tick_rate_auto_throttle_core
    import trat_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   second_elapsed,
    input  logic [MEM_W-1:0]       memory_bytes,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [SLEEP_OUT_W-1:0] sleep_ms,
    output logic                   cpu_warning_valid,
    output logic [TICK_W-1:0]      cpu_warning_ticks,
    output logic                   ram_warning_valid,
    output logic [MIB_W-1:0]       ram_warning_mib,
    output logic [TICK_W-1:0]      ticks_last_second,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                in_valid_reg;
    logic                in_valid_next;
    logic                in_sec_reg;
    logic [MEM_W-1:0]    in_mem_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    rate_res_t           rate_res_reg;
    ram_res_t            ram_res_reg;
    logic [NOM_W-1:0]    nominal_reg;
    logic [NOM_W-1:0]    nominal_next;
    logic [TARGET_W-1:0] target_reg;
    logic [TARGET_W-1:0] target_next;

    logic                advance;
    logic                fire;
    logic                accept;
    logic                base_load;
    rate_res_t           rate_res;
    ram_res_t            ram_res;

    // The evaluated request moves on whenever the result register is free or being emptied.
    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign in_valid_next  = accept ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
    assign out_valid_next = fire ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);

    always_comb
    begin
        nominal_next = nominal_reg;
        target_next  = target_reg;
        base_load    = 1'b0;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_NOMINAL:
                begin
                    nominal_next = cfg_data[NOM_W-1:0];
                end
                CFG_TARGET:
                begin
                    target_next = cfg_data[TARGET_W-1:0];
                end
                CFG_BASELINE:
                begin
                    base_load = 1'b1;
                end
                default:
                begin
                    nominal_next = nominal_reg;
                end
            endcase
        end
    end

    trat_rate u_rate (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .second_elapsed (in_sec_reg),
        .nominal        (nominal_reg),
        .target         (target_reg),
        .res            (rate_res)
    );

    trat_ram u_ram (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .memory_bytes (in_mem_reg),
        .base_load    (base_load),
        .base_value   (cfg_data[MEM_W-1:0]),
        .res          (ram_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            nominal_reg   <= NOMINAL_RESET;
            target_reg    <= TARGET_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            nominal_reg   <= nominal_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_sec_reg <= second_elapsed;
            in_mem_reg <= memory_bytes;
        end
        if (fire)
        begin
            rate_res_reg <= rate_res;
            ram_res_reg  <= ram_res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign sleep_ms          = rate_res_reg.sleep_ms;
    assign cpu_warning_valid = rate_res_reg.cpu_warning_valid;
    assign cpu_warning_ticks = rate_res_reg.cpu_warning_ticks;
    assign ticks_last_second = rate_res_reg.ticks_last_second;
    assign ram_warning_valid = ram_res_reg.ram_warning_valid;
    assign ram_warning_mib   = ram_res_reg.ram_warning_mib;

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the tick rate auto throttle core.
module tb_top;
    import trat_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int HOLD_CYCLES   = 64;
    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 140;

    typedef struct packed {
        logic [SLEEP_OUT_W-1:0] sleep_ms;
        logic                   cpu_valid;
        logic [TICK_W-1:0]      cpu_ticks;
        logic                   ram_valid;
        logic [MIB_W-1:0]       ram_mib;
        logic [TICK_W-1:0]      last_ticks;
    } tick_report_t;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic                  sec;
        logic [MEM_W-1:0]      mem;
        bit                    typed;
        tick_report_t          want;
    } drill_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   second_elapsed;
    logic [MEM_W-1:0]       memory_bytes;
    logic                   out_valid;
    logic                   out_stall;
    logic [SLEEP_OUT_W-1:0] sleep_ms;
    logic                   cpu_warning_valid;
    logic [TICK_W-1:0]      cpu_warning_ticks;
    logic                   ram_warning_valid;
    logic [MIB_W-1:0]       ram_warning_mib;
    logic [TICK_W-1:0]      ticks_last_second;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted state of the block.
    logic [NOM_W-1:0]          nom_rate;
    logic [TARGET_W-1:0]       target_rate;
    logic [TICK_W-1:0]         tick_cnt;
    logic [TICK_W-1:0]         last_ticks;
    logic signed [SLEEP_W-1:0] sleep_amt;
    logic [TICK_W-1:0]         probe_rate [PROBE_CNT];
    logic [PROBE_IDX_W-1:0]    probe_sel;
    logic [MEM_W-1:0]          peak_mem;

    tick_report_t pending_reports [$];
    drill_row_t   drill [$];

    logic [NOM_W-1:0]    phase_nominal [RANDOM_PHASES] = '{50, 1, 20, 1000, 0, 10, 1023, 30};
    logic [TARGET_W-1:0] phase_target  [RANDOM_PHASES] = '{60, 0, 45, 65535, 30, 1, 100, 55};

    bit calm = 1'b0;
    bit hold_out = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int ticks_sent = 0;
    int reports_checked = 0;
    int reg_writes = 0;
    int cpu_seen = 0;
    int ram_seen = 0;
    int sleep_peak = 0;

    tick_rate_auto_throttle_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .second_elapsed    (second_elapsed),
        .memory_bytes      (memory_bytes),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .sleep_ms          (sleep_ms),
        .cpu_warning_valid (cpu_warning_valid),
        .cpu_warning_ticks (cpu_warning_ticks),
        .ram_warning_valid (ram_warning_valid),
        .ram_warning_mib   (ram_warning_mib),
        .ticks_last_second (ticks_last_second),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic void nudge_sleep(input int delta);
        int v;
        v = int'(sleep_amt) + delta;
        if (v > int'(SLEEP_MAX))
        begin
            v = int'(SLEEP_MAX);
        end
        if (v < int'(SLEEP_MIN))
        begin
            v = int'(SLEEP_MIN);
        end
        sleep_amt = v[SLEEP_W-1:0];
    endfunction

    // Close one probe of the sleep search and decide whether to move the sleep or retest.
    function automatic void close_second_search();
        logic [TICK_W:0] want;
        logic            retest;
        int              i;
        want = nom_rate + WANT_MARGIN;
        if (target_rate > want)
        begin
            want = target_rate;
        end
        retest = 1'b0;
        if (probe_sel != PROBE_NONE)
        begin
            if (probe_rate[probe_sel] == '0)
            begin
                probe_rate[probe_sel] = tick_cnt;
            end
            if (probe_sel == PROBE_UP)
            begin
                nudge_sleep(-1);
            end
            else if (probe_sel == PROBE_DOWN)
            begin
                nudge_sleep(1);
            end
        end
        probe_sel = PROBE_NONE;
        for (i = 0; i < PROBE_CNT; i++)
        begin
            if (probe_sel == PROBE_NONE && probe_rate[i] == '0)
            begin
                probe_sel = i[PROBE_IDX_W-1:0];
            end
        end
        if (probe_sel == PROBE_UP)
        begin
            nudge_sleep(1);
        end
        else if (probe_sel == PROBE_DOWN)
        begin
            nudge_sleep(-1);
        end
        if (probe_rate[PROBE_CUR] != '0 && probe_rate[PROBE_UP] != '0
            && probe_rate[PROBE_DOWN] != '0)
        begin
            if (probe_rate[PROBE_CUR] < probe_rate[PROBE_UP]
                || probe_rate[PROBE_CUR] > probe_rate[PROBE_DOWN])
            begin
                retest = 1'b1;
            end
            else if (tick_cnt >= want)
            begin
                if (tick_cnt > probe_rate[PROBE_DOWN] || probe_rate[PROBE_UP] > want)
                begin
                    nudge_sleep(1);
                    retest = 1'b1;
                end
            end
            else if (sleep_amt > 0)
            begin
                nudge_sleep(-1);
                retest = 1'b1;
            end
            if (retest)
            begin
                for (i = 0; i < PROBE_CNT; i++)
                begin
                    probe_rate[i] = '0;
                end
            end
        end
    endfunction

    function automatic tick_report_t predict_tick(input logic sec, input logic [MEM_W-1:0] mem);
        tick_report_t r;
        r = '0;
        if (tick_cnt != TICK_SAT)
        begin
            tick_cnt = tick_cnt + 1'b1;
        end
        if (sec)
        begin
            if (tick_cnt < nom_rate)
            begin
                r.cpu_valid = 1'b1;
                r.cpu_ticks = tick_cnt;
            end
            if (target_rate != '0)
            begin
                close_second_search();
            end
            last_ticks = tick_cnt;
            tick_cnt = '0;
        end
        if (target_rate != '0 && sleep_amt > 0)
        begin
            r.sleep_ms = (int'(sleep_amt) > int'(SLEEP_OUT_MAX)) ? SLEEP_OUT_MAX
                                                                 : sleep_amt[SLEEP_OUT_W-1:0];
        end
        if (mem > peak_mem && (mem - peak_mem) > RAM_STEP_BYTES)
        begin
            r.ram_valid = 1'b1;
            r.ram_mib = mem[MEM_W-1:MIB_SHIFT];
            peak_mem = mem;
        end
        r.last_ticks = last_ticks;
        return r;
    endfunction

    // Next second's length in ticks: mostly near the search's aim if that is at most 80.
    function automatic int pick_second_len();
        int want;
        want = int'(nom_rate) + int'(WANT_MARGIN);
        if (int'(target_rate) > want)
        begin
            want = int'(target_rate);
        end
        if ($urandom_range(0, 9) == 0 || want > 80)
        begin
            return int'($urandom_range(1, 60));
        end
        return want + int'($urandom_range(0, 8)) - 4;
    endfunction

    function automatic drill_row_t tick_row(input logic sec, input logic [MEM_W-1:0] mem);
        drill_row_t r;
        r = '{ROW_TICK, '0, '0, sec, mem, 1'b0, '0};
        return r;
    endfunction

    // A zero warning value means no warning; sleep is zero while throttling is off.
    function automatic drill_row_t typed_row(input logic sec, input logic [MEM_W-1:0] mem,
                                             input logic [TICK_W-1:0] cpu_ticks,
                                             input logic [MIB_W-1:0] ram_mib,
                                             input logic [TICK_W-1:0] last);
        drill_row_t r;
        r = '{ROW_TICK, '0, '0, sec, mem, 1'b1, '0};
        r.want.cpu_valid = (cpu_ticks != '0);
        r.want.cpu_ticks = cpu_ticks;
        r.want.ram_valid = (ram_mib != '0);
        r.want.ram_mib = ram_mib;
        r.want.last_ticks = last;
        return r;
    endfunction

    function automatic drill_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] val);
        drill_row_t r;
        r = '{ROW_WRITE, idx, val, 1'b0, '0, 1'b0, '0};
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_NOMINAL:  nom_rate = val[NOM_W-1:0];
            CFG_TARGET:   target_rate = val[TARGET_W-1:0];
            CFG_BASELINE: peak_mem = val[MEM_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    // Offer one tick request and hold it until the block takes it.
    task automatic push_tick(input logic sec, input logic [MEM_W-1:0] mem, input bit typed,
                             input tick_report_t want);
        int           gap;
        tick_report_t pred;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        second_elapsed <= sec;
        memory_bytes <= mem;
        do @(posedge clk); while (in_stall);
        pred = predict_tick(sec, mem);
        pending_reports.push_back(typed ? want : pred);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input int p, input bit with_hold, input bit with_pause);
        int               k;
        int               in_sec;
        int               sec_len;
        logic             sec;
        logic [MEM_W-1:0] mem;
        wait_drained();
        write_reg(CFG_NOMINAL, phase_nominal[p]);
        write_reg(CFG_TARGET, phase_target[p]);
        case (p % 3)
            0:       write_reg(CFG_BASELINE, '0);
            1:       write_reg(CFG_BASELINE, {CFG_DATA_W{1'b1}});
            default: write_reg(CFG_BASELINE, CFG_DATA_W'({$urandom(), $urandom()}));
        endcase
        in_sec = 0;
        sec_len = pick_second_len();
        for (k = 0; k < PHASE_TICKS; k++)
        begin
            if (with_hold && k == PHASE_TICKS / 3)
            begin
                hold_out = 1'b1;
            end
            if (with_pause && k == PHASE_TICKS / 2)
            begin
                wait_drained();
            end
            in_sec++;
            sec = (in_sec >= sec_len);
            if (sec)
            begin
                in_sec = 0;
                sec_len = pick_second_len();
            end
            case ($urandom_range(0, 9))
                0, 1:    mem = MEM_W'({$urandom(), $urandom()});
                2, 3, 4: mem = peak_mem + RAM_STEP_BYTES - 40'd2 + MEM_W'($urandom_range(0, 4));
                5, 6:    mem = peak_mem + MEM_W'($urandom_range(0, 1 << 26));
                7:       mem = peak_mem - MEM_W'($urandom_range(0, 1 << 20));
                default: mem = peak_mem;
            endcase
            push_tick(sec, mem, 1'b0, '0);
        end
    endtask

    // Receiver: random stall bursts, or one long hold when asked for.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        tick_report_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result arrived with no tick request outstanding");
                fail_count++;
            end
            else
            begin
                exp_r = pending_reports.pop_front();
                check_field("sleep_ms", exp_r.sleep_ms, sleep_ms);
                check_field("cpu_warning_valid", exp_r.cpu_valid, cpu_warning_valid);
                check_field("cpu_warning_ticks", exp_r.cpu_ticks, cpu_warning_ticks);
                check_field("ram_warning_valid", exp_r.ram_valid, ram_warning_valid);
                check_field("ram_warning_mib", exp_r.ram_mib, ram_warning_mib);
                check_field("ticks_last_second", exp_r.last_ticks, ticks_last_second);
                reports_checked++;
                cpu_seen += cpu_warning_valid;
                ram_seen += ram_warning_valid;
                if (int'(sleep_ms) > sleep_peak)
                begin
                    sleep_peak = int'(sleep_ms);
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        int p;
        rst_n = 1'b0;
        in_valid = 1'b0;
        second_elapsed = 1'b0;
        memory_bytes = '0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        nom_rate = NOMINAL_RESET;
        target_rate = TARGET_RESET;
        tick_cnt = TICK_RESET;
        last_ticks = '0;
        sleep_amt = SLEEP_ZERO;
        for (p = 0; p < PROBE_CNT; p++)
        begin
            probe_rate[p] = '0;
        end
        probe_sel = PROBE_NONE;
        peak_mem = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: reset values, field extremes, memory threshold, throttle corners.
        drill.push_back(typed_row(1'b0, '0, 0, 0, 0));
        drill.push_back(typed_row(1'b1, '0, 0, 0, 1002));
        drill.push_back(typed_row(1'b1, '0, 1, 0, 1));
        drill.push_back(typed_row(1'b0, 40'd52428800, 0, 0, 1));
        drill.push_back(typed_row(1'b0, 40'd52428801, 0, 50, 1));
        drill.push_back(typed_row(1'b0, 40'hFF_FFFF_FFFF, 0, 20'hFFFFF, 1));
        drill.push_back(typed_row(1'b0, '0, 0, 0, 1));
        drill.push_back(typed_row(1'b1, 40'hFF_FFFF_FFFF, 5, 0, 5));
        drill.push_back(write_row(CFG_BASELINE, '0));
        drill.push_back(typed_row(1'b0, 40'h55_5555_5555, 0, 20'h55555, 5));
        drill.push_back(typed_row(1'b0, 40'hAA_AAAA_AAAA, 0, 20'hAAAAA, 5));
        drill.push_back(write_row(CFG_TARGET, 40'hFFFF));
        drill.push_back(write_row(CFG_NOMINAL, '0));
        drill.push_back(tick_row(1'b1, '0));
        drill.push_back(tick_row(1'b1, 40'h55_5555_5555));
        drill.push_back(tick_row(1'b0, '0));
        drill.push_back(tick_row(1'b1, '0));
        drill.push_back(tick_row(1'b1, '0));
        drill.push_back(write_row(CFG_NOMINAL, 40'd1000));
        drill.push_back(tick_row(1'b1, '0));
        drill.push_back(tick_row(1'b0, '0));
        drill.push_back(tick_row(1'b1, '0));
        drill.push_back(write_row(CFG_TARGET, '0));
        drill.push_back(write_row(CFG_BASELINE, 40'hFF_FFFF_FFFF));
        drill.push_back(tick_row(1'b1, 40'hFF_FFFF_FFFF));
        foreach (drill[i])
        begin
            if (drill[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(drill[i].reg_idx, drill[i].reg_val);
            end
            else
            begin
                push_tick(drill[i].sec, drill[i].mem, drill[i].typed, drill[i].want);
            end
        end

        for (p = 0; p < RANDOM_PHASES - 1; p++)
        begin
            run_phase(p, p == 2, p == 4);
        end

        // The last phase runs with no idling on either side.
        calm = 1'b1;
        run_phase(RANDOM_PHASES - 1, 1'b0, 1'b0);
        wait_drained();

        $display("Sent %0d ticks over %0d register writes; %0d results checked.",
                 ticks_sent, reg_writes, reports_checked);
        $display("Saw %0d CPU warnings, %0d RAM warnings, sleep up to %0d ms.",
                 cpu_seen, ram_seen, sleep_peak);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/trat_pkg.sv
hw/rtl/trat_rate.sv
hw/rtl/trat_ram.sv
hw/rtl/tick_rate_auto_throttle_core.sv
sim/tb_top.sv
